/* hw/rtl/rbrd_pkg.sv */
// ----------------------------------------------------------------------------
// Run-length byte decoder package
// Shared constants, status codes and the target saturation function.
// ----------------------------------------------------------------------------
package rbrd_pkg;

    localparam int COUNT_BITS = 24;
    localparam int SIZE_W     = 24;
    localparam int BYTE_W     = 8;
    localparam int RUN_W      = 7;
    localparam int STATUS_W   = 3;

    localparam logic [BYTE_W-1:0] BAD_COUNT_BYTE = 8'hFF;
    localparam logic [BYTE_W-1:0] LITERAL_MAX    = 8'h7F;
    localparam logic [BYTE_W-1:0] REPEAT_BIAS    = 8'd127;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK            = 3'd0,
        ST_BAD_COUNT     = 3'd1,
        ST_TRUNC_REPEAT  = 3'd2,
        ST_TRUNC_LITERAL = 3'd3,
        ST_SHORT         = 3'd4
    } status_t;

    // Clips the wanted size to the largest value the output counter holds.
    function automatic logic [COUNT_BITS-1:0] sat_target(input logic [SIZE_W-1:0] want);
        logic [32:0] want_ext;
        logic [32:0] cap;
        want_ext = 33'(want);
        cap      = (33'(1) << COUNT_BITS) - 33'(1);
        return (want_ext < cap) ? COUNT_BITS'(want_ext) : COUNT_BITS'(cap);
    endfunction

endpackage

/* hw/rtl/rle_byte_run_decoder_top.sv */
// ----------------------------------------------------------------------------
// Run-length byte decoder top level
// Decodes a run-length coded byte stream into runs given as value and length.
// ----------------------------------------------------------------------------
// The decoder takes one compressed word per cycle while s_tready is high and
// gives at most one run word per input word. Each input word is decoded in the
// cycle it is accepted; its run goes to the output register, or to the one-entry
// skid buffer behind it while that register holds a waiting result, so input
// stalls only after the sink has held off m_tready for two results. A literal
// byte below the target gives a run of length one, a repeat pair gives one run on
// its value byte unless clipped to zero, and the last input word always gives a
// result with m_tlast set and the end status in m_tuser. On an error status every
// run already delivered for that stream must be discarded. The user must write
// expected_size through cfg_wr_en only while the decoder is idle; nothing enforces it.
module rle_byte_run_decoder_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [rbrd_pkg::SIZE_W-1:0]   cfg_wr_data,   // expected_size
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,       // [7:0] in_byte
    input  logic                          s_tlast,       // in_last
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [15:0]                   m_tdata,       // [7:0] out_value, [14:8] out_run_length
    output logic                          m_tlast,       // out_end
    output logic [rbrd_pkg::STATUS_W-1:0] m_tuser        // [2:0] out_status
);
    import rbrd_pkg::*;

    typedef enum logic [1:0] {
        MODE_COUNT   = 2'd0,
        MODE_REPEAT  = 2'd1,
        MODE_LITERAL = 2'd2,
        MODE_DRAIN   = 2'd3
    } mode_t;

    typedef struct packed {
        logic [BYTE_W-1:0]   value;
        logic [RUN_W-1:0]    run_length;
        logic                last;
        logic [STATUS_W-1:0] status;
    } result_t;

    logic [SIZE_W-1:0]     expected_size_reg;
    mode_t                 mode_reg, mode_next;
    logic [BYTE_W-1:0]     remain_reg, remain_next;
    logic [RUN_W-1:0]      repeat_reg, repeat_next;
    logic [COUNT_BITS-1:0] produced_reg, produced_next;
    logic [STATUS_W-1:0]   error_reg, error_next;

    result_t out_reg, skid_reg, res;
    logic    out_valid_reg, skid_valid_reg;

    logic                  accept, pop, push, have;
    logic [COUNT_BITS-1:0] lim, room;
    logic [RUN_W-1:0]      run_len;
    logic [BYTE_W-1:0]     rep_calc;
    status_t               status;

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign pop      = out_valid_reg && m_tready;
    assign lim      = sat_target(expected_size_reg);
    assign room     = (lim > produced_reg) ? lim - produced_reg : '0;
    assign rep_calc = s_tdata - REPEAT_BIAS;

    always_comb begin
        mode_next     = mode_reg;
        remain_next   = remain_reg;
        repeat_next   = repeat_reg;
        produced_next = produced_reg;
        error_next    = error_reg;
        run_len       = '0;
        have          = 1'b0;
        status        = ST_OK;
        unique case (mode_reg)
            MODE_COUNT: begin
                if (produced_reg < lim) begin
                    if (s_tdata == BAD_COUNT_BYTE) begin
                        error_next = ST_BAD_COUNT;
                        mode_next  = MODE_DRAIN;
                    end else if (s_tdata > LITERAL_MAX) begin
                        repeat_next = rep_calc[RUN_W-1:0];
                        mode_next   = MODE_REPEAT;
                    end else begin
                        remain_next = s_tdata + BYTE_W'(1);
                        mode_next   = MODE_LITERAL;
                    end
                end
            end
            MODE_REPEAT: begin
                run_len       = (room < COUNT_BITS'(repeat_reg)) ? room[RUN_W-1:0] : repeat_reg;
                produced_next = produced_reg + COUNT_BITS'(run_len);
                have          = (run_len != '0);
                mode_next     = MODE_COUNT;
            end
            MODE_LITERAL: begin
                if (produced_reg < lim) begin
                    run_len       = RUN_W'(1);
                    produced_next = produced_reg + COUNT_BITS'(1);
                    have          = 1'b1;
                end
                remain_next = remain_reg - BYTE_W'(1);
                if (remain_next == '0) begin
                    mode_next = MODE_COUNT;
                end
            end
            MODE_DRAIN: begin
            end
            default: begin
            end
        endcase

        if (error_next != '0) begin
            status = status_t'(error_next);
        end else if (mode_next == MODE_REPEAT) begin
            status = ST_TRUNC_REPEAT;
        end else if (mode_next == MODE_LITERAL) begin
            status = ST_TRUNC_LITERAL;
        end else if (produced_next < lim) begin
            status = ST_SHORT;
        end else begin
            status = ST_OK;
        end

        res.value      = s_tdata;
        res.run_length = run_len;
        res.last       = s_tlast;
        res.status     = ST_OK;
        if (s_tlast) begin
            res.status = status;
            if (status == ST_BAD_COUNT || status == ST_TRUNC_REPEAT ||
                status == ST_TRUNC_LITERAL) begin
                res.value      = '0;
                res.run_length = '0;
            end else if (run_len == '0 && mode_reg != MODE_REPEAT) begin
                res.value = '0;
            end
            mode_next     = MODE_COUNT;
            remain_next   = '0;
            repeat_next   = '0;
            produced_next = '0;
            error_next    = '0;
        end
        push = accept && (s_tlast || have);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_size_reg <= '0;
            mode_reg          <= MODE_COUNT;
            remain_reg        <= '0;
            repeat_reg        <= '0;
            produced_reg      <= '0;
            error_reg         <= '0;
            out_valid_reg     <= 1'b0;
            skid_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                expected_size_reg <= cfg_wr_data;
            end
            if (accept) begin
                mode_reg     <= mode_next;
                remain_reg   <= remain_next;
                repeat_reg   <= repeat_next;
                produced_reg <= produced_next;
                error_reg    <= error_next;
            end
            if (skid_valid_reg) begin
                if (pop) begin
                    skid_valid_reg <= 1'b0;
                end
            end else if (push) begin
                if (out_valid_reg && !pop) begin
                    skid_valid_reg <= 1'b1;
                end else begin
                    out_valid_reg <= 1'b1;
                end
            end else if (pop) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                out_reg <= skid_reg;
            end
        end else if (push) begin
            if (out_valid_reg && !pop) begin
                skid_reg <= res;
            end else begin
                out_reg <= res;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg.run_length, out_reg.value};
    assign m_tlast  = out_reg.last;
    assign m_tuser  = out_reg.status;

endmodule

/* hw/rtl/rbrd_checker.sv */
// ----------------------------------------------------------------------------
// Run-length byte decoder checker
// Port-level assertions on the run words, bound to the decoder top level.
// ----------------------------------------------------------------------------
module rbrd_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [15:0]                   m_tdata,
    input logic                          m_tlast,
    input logic [rbrd_pkg::STATUS_W-1:0] m_tuser
);
    import rbrd_pkg::*;

    // A run word that does not end the stream carries no status.
    a_mid_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tuser == ST_OK)
        else $error("status set on a word that is not the last");

    // A run word that does not end the stream always carries data.
    a_mid_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata[14:8] != '0)
        else $error("empty run before the end of the stream");

    // Error statuses come with an empty run.
    a_err_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_BAD_COUNT || m_tuser == ST_TRUNC_REPEAT ||
                     m_tuser == ST_TRUNC_LITERAL) |-> m_tdata == '0)
        else $error("error status with run data");

    // A stalled word stays offered unchanged.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
                                  $stable(m_tlast) && $stable(m_tuser))
        else $error("stalled word changed");

endmodule

bind rle_byte_run_decoder_top rbrd_checker u_rbrd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

/* tb/tb_rle_byte_run_decoder_top.sv */
// ----------------------------------------------------------------------------
// Run-length byte decoder testbench
// Feeds compressed byte streams into the decoder, predicts every run word and
// end status from its own model of the decoding rules, and compares each run
// word on the master side against the oldest prediction. Covers directed
// corner cases, random well-formed and broken streams under several target
// sizes, random idling on both sides and a long sink stall.
// ----------------------------------------------------------------------------
module tb_rle_byte_run_decoder_top;
    import rbrd_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int HOLD_CYCLES  = 150;
    localparam int MAX_PRINTS   = 50;
    localparam int RANDOM_BYTES = 1300;

    typedef enum logic [1:0] {
        DM_COUNT   = 2'd0,
        DM_REPEAT  = 2'd1,
        DM_LITERAL = 2'd2,
        DM_DRAIN   = 2'd3
    } dec_mode_t;

    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic [RUN_W-1:0]  length;
        logic              done;
        status_t           status;
    } run_word_t;

    typedef logic [7:0] byte_q_t[$];

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [SIZE_W-1:0]     cfg_wr_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [15:0]           m_tdata;
    logic                  m_tlast;
    logic [STATUS_W-1:0]   m_tuser;

    rle_byte_run_decoder_top u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

    // Decoder model state.
    logic [SIZE_W-1:0] size_q = '0;
    dec_mode_t         mode_q = DM_COUNT;
    int                run_left = 0;
    int                rep_len = 0;
    longint            made = 0;
    status_t           err_st = ST_OK;
    int                bytes_used = 0;

    run_word_t runs_due[$];
    int        mismatches = 0;
    int        cycle_count = 0;
    bit        tx_idle = 0;
    bit        rx_idle = 0;
    int        hold_req = 0;
    int        hold_seen = 0;
    int        rx_gap = 0;
    run_word_t got_run;
    run_word_t want_run;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic longint decode_target();
        longint cap;
        cap = (longint'(1) << COUNT_BITS) - 1;
        return (longint'(size_q) < cap) ? longint'(size_q) : cap;
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic last);
        longint    lim;
        longint    room;
        longint    n;
        run_word_t r;
        bit        have;
        lim  = decode_target();
        r    = '{value: '0, length: '0, done: 1'b0, status: ST_OK};
        have = 0;
        bytes_used++;
        case (mode_q)
            DM_COUNT: begin
                if (made < lim) begin
                    if (b == BAD_COUNT_BYTE) begin
                        err_st = ST_BAD_COUNT;
                        mode_q = DM_DRAIN;
                    end else if (b > LITERAL_MAX) begin
                        rep_len = int'(b) - int'(REPEAT_BIAS);
                        mode_q  = DM_REPEAT;
                    end else begin
                        run_left = int'(b) + 1;
                        mode_q   = DM_LITERAL;
                    end
                end
            end
            DM_REPEAT: begin
                room = (lim > made) ? lim - made : 0;
                n = (longint'(rep_len) > room) ? room : longint'(rep_len);
                r.value  = b;
                r.length = RUN_W'(n);
                made += n;
                have = (n > 0);
                mode_q = DM_COUNT;
            end
            DM_LITERAL: begin
                if (made < lim) begin
                    r.value  = b;
                    r.length = RUN_W'(1);
                    made++;
                    have = 1;
                end
                run_left--;
                if (run_left == 0) begin
                    mode_q = DM_COUNT;
                end
            end
            default: ;
        endcase
        if (last) begin
            if (err_st != ST_OK) begin
                r.status = err_st;
            end else if (mode_q == DM_REPEAT) begin
                r.status = ST_TRUNC_REPEAT;
            end else if (mode_q == DM_LITERAL) begin
                r.status = ST_TRUNC_LITERAL;
            end else if (made < lim) begin
                r.status = ST_SHORT;
            end else begin
                r.status = ST_OK;
            end
            if (r.status == ST_BAD_COUNT || r.status == ST_TRUNC_REPEAT ||
                r.status == ST_TRUNC_LITERAL) begin
                r.value  = '0;
                r.length = '0;
            end
            r.done = 1'b1;
            runs_due = {runs_due, r};
            mode_q   = DM_COUNT;
            run_left = 0;
            rep_len  = 0;
            made     = 0;
            err_st   = ST_OK;
        end else if (have) begin
            runs_due = {runs_due, r};
        end
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (mismatches < MAX_PRINTS) begin
            $display("mismatch in %s: got %0d, expected %0d (cycle %0d)",
                     what, got, want, cycle_count);
        end
        mismatches++;
    endtask

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Sink: random gap after each accepted word while rx_idle is set, plus a long hold-off on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_gap = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                rx_gap = rx_idle ? $urandom_range(0, 12) : 0;
            end
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                rx_gap = HOLD_CYCLES;
            end
            if (rx_gap > 0) begin
                m_tready <= 1'b0;
                rx_gap--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_run = '{value: m_tdata[7:0], length: m_tdata[14:8], done: m_tlast,
                        status: status_t'(m_tuser)};
            if (runs_due.size() == 0) begin
                report_mismatch("unexpected run word, value", got_run.value, -1);
            end else begin
                want_run = runs_due.pop_front();
                if (got_run.value !== want_run.value)
                    report_mismatch("value", got_run.value, want_run.value);
                if (got_run.length !== want_run.length)
                    report_mismatch("run length", got_run.length, want_run.length);
                if (got_run.done !== want_run.done)
                    report_mismatch("end flag", got_run.done, want_run.done);
                if (got_run.status !== want_run.status)
                    report_mismatch("status", got_run.status, want_run.status);
            end
        end
    end

    task automatic send_word(input logic [7:0] b, input logic last);
        int gap;
        gap = tx_idle ? $urandom_range(0, 12) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= b;
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        decode_byte(b, last);
    endtask

    task automatic send_stream(input byte_q_t bytes);
        foreach (bytes[i]) begin
            send_word(bytes[i], i == bytes.size() - 1);
        end
    endtask

    task automatic write_size(input logic [SIZE_W-1:0] size);
        s_tvalid <= 1'b0;
        while (runs_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= size;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        size_q = size;
    endtask

    task automatic test_directed();
        byte_q_t s;
        tx_idle = 1;
        rx_idle = 1;
        write_size(24'd20);
        // Short repeat, a repeat clipped at the target, then a dropped count.
        s = {8'h80, 8'hAB, 8'hFE, 8'h55, 8'h01};
        send_stream(s);
        // A literal carrying 0xFF as data, then 0xFF as a count.
        s = {8'h00, 8'hFF, 8'hFF, 8'h12, 8'h34};
        send_stream(s);
        s = {8'h85};
        send_stream(s);
        s = {8'h7F};
        send_stream(s);
        s = {8'h02, 8'h11, 8'h22};
        send_stream(s);
        s = {8'h80, 8'h77};
        send_stream(s);
        write_size(24'd0);
        s = {8'h05, 8'h00};
        send_stream(s);
        // Literal bytes past the target are consumed without output.
        write_size(24'd2);
        s = {8'h03, 8'hA1, 8'hA2, 8'hA3, 8'hA4};
        send_stream(s);
    endtask

    task automatic build_stream(output byte_q_t s, input bit broken);
        int runs;
        int cnt;
        int pos;
        s = {};
        runs = $urandom_range(1, 8);
        for (int r = 0; r < runs; r++) begin
            if ($urandom_range(0, 1) == 1) begin
                s = {s, 8'($urandom_range(128, 254))};
                s = {s, 8'($urandom)};
            end else begin
                cnt = ($urandom_range(0, 15) == 0) ? $urandom_range(16, 127)
                                                    : $urandom_range(0, 7);
                s = {s, 8'(cnt)};
                repeat (cnt + 1) s = {s, 8'($urandom)};
            end
        end
        if (broken) begin
            case ($urandom_range(0, 3))
                0: begin
                    pos = $urandom_range(0, s.size() - 1);
                    s.insert(pos, BAD_COUNT_BYTE);
                end
                1: begin
                    repeat ($urandom_range(1, 3)) begin
                        if (s.size() > 1) void'(s.pop_back());
                    end
                end
                2: begin
                    s = {};
                    repeat ($urandom_range(1, 20)) s = {s, 8'($urandom)};
                end
                default: s = {s, 8'($urandom)};
            endcase
        end
    endtask

    task automatic test_random_streams();
        byte_q_t s;
        int      start;
        int      phase;
        logic [SIZE_W-1:0] size;
        start = bytes_used;
        phase = 0;
        while (bytes_used - start < RANDOM_BYTES && phase < 200) begin
            case (phase)
                0: size = 24'hFFFFFF;
                1: size = 24'd1;
                2: size = 24'd0;
                3: size = SIZE_W'($urandom);
                default: begin
                    case ($urandom_range(0, 3))
                        0: size = 24'hFFFFFF;
                        1: size = SIZE_W'($urandom);
                        default: size = SIZE_W'($urandom_range(0, 200));
                    endcase
                end
            endcase
            write_size(size);
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(3, 8)) begin
                build_stream(s, $urandom_range(0, 5) == 0);
                send_stream(s);
            end
            phase++;
        end
    endtask

    task automatic test_backpressure();
        byte_q_t s;
        write_size(24'hFFFFFF);
        tx_idle = 0;
        rx_idle = 0;
        hold_req <= hold_req + 1;
        s = {8'h3F};
        repeat (64) s = {s, 8'($urandom)};
        s = {s, 8'h90};
        s = {s, 8'h3C};
        send_stream(s);
    endtask

    initial begin
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tlast     <= 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_backpressure();
        test_random_streams();

        s_tvalid <= 1'b0;
        while (runs_due.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
